>>> hw/rtl/bgc_pkg.sv
// Shared types, constants and helpers of the button gesture classifier.
package bgc_pkg;

	localparam int NUM_BUTTONS_DEF = 5;
	localparam int MASK_W = 5;
	localparam int CFG_W = 16;
	localparam int TIME_W = 32;
	localparam int SEC_W = 23;
	localparam int TYPE_W = 2;
	localparam int IDX_W = 2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_W-1:0] DOUBLE_RST = 16'd400;
	localparam logic [CFG_W-1:0] HOLD_RST = 16'd2000;
	localparam logic [CFG_W-1:0] COMBO_RST = 16'd150;

	localparam logic [IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [IDX_W-1:0] REG_DOUBLE = 2'd1;
	localparam logic [IDX_W-1:0] REG_HOLD = 2'd2;
	localparam logic [IDX_W-1:0] REG_COMBO = 2'd3;

	localparam logic [TYPE_W-1:0] TYPE_SINGLE = 2'd0;
	localparam logic [TYPE_W-1:0] TYPE_HOLD = 2'd1;
	localparam logic [TYPE_W-1:0] TYPE_DOUBLE = 2'd2;

	// ms / 1000 = (ms >> 3) / 125; ceil(2^36 / 125) is exact for 29-bit operands
	localparam logic [29:0] SEC_RECIP = 30'd549755814;
	localparam int SEC_SHIFT = 36;

	// Timing settings shared by all lanes
	typedef struct packed {
		logic [CFG_W-1:0] debounce;
		logic [CFG_W-1:0] dbl;
		logic [CFG_W-1:0] hold;
		logic [CFG_W-1:0] combo;
	} cfg_t;

	// One queued event
	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic [TYPE_W-1:0] kind;
	} evt_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_WALK,
		ST_EMIT
	} state_t;

endpackage

>>> hw/rtl/bgc_lane.sv
// Per-button debounce lane: tracks the raw level and flags a stable edge.
module bgc_lane
	import bgc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic              raw,
	input  logic [TIME_W-1:0] now,
	input  logic [CFG_W-1:0]  debounce,
	output logic              edge_hit
);

	logic              raw_prev_q;
	logic [TIME_W-1:0] change_q;
	logic [TIME_W-1:0] ref_t;
	logic [TIME_W-1:0] age;
	logic              stable_q;

	// Time of the last raw change as seen by this poll
	assign ref_t = (raw != raw_prev_q) ? now : change_q;
	assign age = now - ref_t;
	assign edge_hit = (raw != stable_q) && (age >= {{(TIME_W-CFG_W){1'b0}}, debounce});

	// Update raw history and the stable level when a poll is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_prev_q <= 1'b1;
			change_q <= '0;
			stable_q <= 1'b1;
		end else if (load) begin
			raw_prev_q <= raw;
			change_q <= ref_t;
			if (edge_hit)
				stable_q <= raw;
		end
	end

endmodule

>>> hw/rtl/button_gesture_classifier.sv
// Top level of the button gesture classifier.
// Usage: each slave beat is one poll, tdata = {now_ms, raw_levels} (raw bits
// 0 = pressed). The block emits zero or more events on the master side, each
// tdata = {time_seconds, gesture_type, button_mask, seq_num}, with tlast on
// the final event of a poll. A poll that causes no event produces no beat.
// Debounce runs in one lane per button in the accept cycle; ms-to-seconds
// conversion is registered (reciprocal multiply); the gesture walk then
// visits the buttons in turn, and queued events are offered one per cycle
// after it while the master is ready. One poll is worked at a time; the
// slave side is not ready until all events of the previous poll have been
// taken. A stalled master holds its beat.
// Reset releases all buttons, clears gesture state, restarts the sequence at
// 1 and loads the default timing registers.
module button_gesture_classifier
	import bgc_pkg::*;
#(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // raw_levels[4:0], now_ms[36:5], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // seq_num[31:0], button_mask[36:32],
	                               // gesture_type[38:37], time_seconds[61:39]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int QD = 2 * NUM_BUTTONS;
	localparam int QW = $clog2(QD + 1);

	cfg_t cfg_q;
	state_t state_q, state_d;

	logic [NUM_BUTTONS-1:0] raw_in, edge_v, edge_q;
	logic [NUM_BUTTONS-1:0] stable_q, combo_q, holdd_q, pend_q;
	logic [TIME_W-1:0] press_q [NUM_BUTTONS];
	logic [TIME_W-1:0] rel_q [NUM_BUTTONS];
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] seq_q;
	logic [BW-1:0] btn_q;
	logic [58:0] sec_prod;
	logic [SEC_W-1:0] sec_q;
	evt_t q_mem [QD];
	logic [QW-1:0] wr_q, rd_q;
	logic accept;

	assign accept = s_tvalid && s_tready;

	// Raw level per lane; buttons beyond the input width read as pressed
	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++)
			raw_in[i] = (i < MASK_W) ? s_tdata[i] : 1'b0;
	end

	genvar g;
	generate
		for (g = 0; g < NUM_BUTTONS; g++) begin : g_lane
			bgc_lane u_lane (
				.clk(clk), .arst_n(arst_n), .load(accept), .raw(raw_in[g]),
				.now(s_tdata[36:5]), .debounce(cfg_q.debounce), .edge_hit(edge_v[g])
			);
		end
	endgenerate

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{DEBOUNCE_RST, DOUBLE_RST, HOLD_RST, COMBO_RST};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce <= cfg_data;
				REG_DOUBLE:   cfg_q.dbl <= cfg_data;
				REG_HOLD:     cfg_q.hold <= cfg_data;
				REG_COMBO:    cfg_q.combo <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_DIV;
			ST_DIV:  state_d = ST_WALK;
			ST_WALK: if (btn_q == BW'(NUM_BUTTONS - 1)) state_d = ST_EMIT;
			ST_EMIT: if (rd_q == wr_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		m_tvalid = (state_q == ST_EMIT) && (rd_q != wr_q);
		m_tlast = (rd_q + QW'(1)) == wr_q;
		m_tdata = {2'b00, sec_q, q_mem[rd_q[QW-1:0] < QW'(QD) ? rd_q : '0].kind,
			q_mem[rd_q < QW'(QD) ? rd_q : '0].mask, seq_q};
	end

	// Seconds by reciprocal multiplication of ms / 8 by 2^36 / 125
	assign sec_prod = now_q[TIME_W-1:3] * SEC_RECIP;

	// Gesture walk: one button per cycle, events pushed into the queue
	always_ff @(posedge clk or negedge arst_n) begin
		logic st, cb, hd, pd, ev;
		logic [TIME_W-1:0] pt, rt;
		logic [NUM_BUTTONS-1:0] cmb, pnd;
		logic [QW-1:0] w;
		logic found;
		int b;
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stable_q <= '1;
			combo_q <= '0;
			holdd_q <= '0;
			pend_q <= '0;
			seq_q <= 32'd1;
			wr_q <= '0;
			rd_q <= '0;
			btn_q <= '0;
			edge_q <= '0;
			now_q <= '0;
			sec_q <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				press_q[i] <= '0;
				rel_q[i] <= '0;
			end
			for (int i = 0; i < QD; i++)
				q_mem[i] <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				edge_q <= edge_v;
				now_q <= s_tdata[36:5];
				btn_q <= '0;
				wr_q <= '0;
				rd_q <= '0;
			end
			// Capture the seconds count of this poll
			if (state_q == ST_DIV)
				sec_q <= sec_prod[SEC_SHIFT +: SEC_W];
			if (state_q == ST_WALK) begin
				b = int'(btn_q);
				w = wr_q;
				st = stable_q[b];
				cb = combo_q[b];
				hd = holdd_q[b];
				pd = pend_q[b];
				pt = press_q[b];
				rt = rel_q[b];
				cmb = combo_q;
				pnd = pend_q;
				found = 1'b0;
				if (edge_q[b]) begin
					st = ~st;
					if (!st) begin
						if (pd && (now_q - rt > {16'd0, cfg_q.dbl})) begin
							q_mem[w] <= '{MASK_W'(1 << b), TYPE_SINGLE};
							w = w + QW'(1);
							pd = 1'b0;
						end
						pt = now_q;
						hd = 1'b0;
						cb = 1'b0;
						for (int o = 0; o < NUM_BUTTONS; o++) begin
							if (!found && o != b && !stable_q[o] && !cmb[o] &&
								(now_q - press_q[o] <= {16'd0, cfg_q.combo})) begin
								found = 1'b1;
								cb = 1'b1;
								cmb[o] = 1'b1;
								pnd[o] = 1'b0;
								pd = 1'b0;
								q_mem[w] <= '{MASK_W'((1 << o) | (1 << b)), TYPE_SINGLE};
								w = w + QW'(1);
							end
						end
					end else begin
						if (cb)
							cb = 1'b0;
						else if (!hd) begin
							if (!pd) begin
								pd = 1'b1;
								rt = now_q;
							end else if (now_q - rt <= {16'd0, cfg_q.dbl}) begin
								pd = 1'b0;
								q_mem[w] <= '{MASK_W'(1 << b), TYPE_DOUBLE};
								w = w + QW'(1);
							end else begin
								q_mem[w] <= '{MASK_W'(1 << b), TYPE_SINGLE};
								w = w + QW'(1);
								rt = now_q;
							end
						end
					end
				end
				ev = !st && !cb && !hd && (now_q - pt >= {16'd0, cfg_q.hold});
				if (ev) begin
					hd = 1'b1;
					pd = 1'b0;
					q_mem[w] <= '{MASK_W'(1 << b), TYPE_HOLD};
					w = w + QW'(1);
				end else if (pd && st && (now_q - rt > {16'd0, cfg_q.dbl})) begin
					pd = 1'b0;
					q_mem[w] <= '{MASK_W'(1 << b), TYPE_SINGLE};
					w = w + QW'(1);
				end
				cmb[b] = cb;
				pnd[b] = pd;
				combo_q <= cmb;
				pend_q <= pnd;
				stable_q[b] <= st;
				holdd_q[b] <= hd;
				press_q[b] <= pt;
				rel_q[b] <= rt;
				wr_q <= w;
				btn_q <= btn_q + BW'(1);
			end
			// Advance the read side on each delivered beat
			if (m_tvalid && m_tready) begin
				rd_q <= rd_q + QW'(1);
				seq_q <= seq_q + 32'd1;
			end
		end
	end

endmodule
